/* hdl/tfce_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfce_pkg: shared types and constants
// Flow record, channel words and controller/datapath command and status.
// ----------------------------------------------------------------------------
package tfce_pkg;

	localparam int unsigned CAPACITY = 32;
	localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_RST = 8'h04;

	localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

	typedef enum logic [0:0] {
		REG_ACTIVE   = 1'b0,
		REG_INACTIVE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_PACKET = 1'b0,
		CMD_FLUSH  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [7:0]  tos;
		logic [15:0] ip_length;
		logic [7:0]  hdr_flags;
		logic [31:0] timestamp_ms;
	} in_word_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [7:0]  tos;
		logic [31:0] packets;
		logic [31:0] octets;
		logic [31:0] first_ms;
		logic [31:0] last_ms;
		logic [7:0]  flags;
	} flow_t;

	typedef struct packed {
		logic [31:0] out_src_addr;
		logic [31:0] out_dst_addr;
		logic [15:0] out_src_port;
		logic [15:0] out_dst_port;
		logic [7:0]  out_protocol;
		logic [7:0]  out_tos;
		logic [31:0] packet_count;
		logic [31:0] octet_count;
		logic [31:0] first_ms;
		logic [31:0] last_ms;
		logic [7:0]  flags_seen;
		logic        last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [0:0]  index;
		logic [31:0] data;
	} cfg_word_t;

	// controller -> datapath
	typedef struct packed {
		logic              load_in;   // capture input word
		logic              rd_en;     // read record of slot rd_slot
		logic [SLOT_W-1:0] rd_slot;
		logic              wr_upd;    // write back updated record (rd data)
		logic              wr_new;    // write new record from input
		logic [SLOT_W-1:0] wr_slot;
		logic              emit;      // hold record, release the previous one
		logic              emit_new;  // emit the new record, not the read one
		logic              emit_last; // release held record as last of run
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       cmd_flush;
		logic       live;
		logic       hit;
		logic       close_now;
		logic       out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

/* hdl/tfce_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfce_if: valid/ready channel
// Generic channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface tfce_in_if;
	logic                valid;
	logic                ready;
	tfce_pkg::in_word_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tfce_out_if;
	logic                valid;
	logic                ready;
	tfce_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tfce_cfg_if;
	logic                valid;
	logic                ready;
	tfce_pkg::cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/tfce_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfce_datapath: flow record store, compare and update
// Holds the flow memory, the captured input word, timeout registers, a hold
// register for the latest exported record and the output register.
// ----------------------------------------------------------------------------
module tfce_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tfce_pkg::in_word_t in_word,
	input  wire logic               cfg_we,
	input  wire tfce_pkg::cfg_word_t cfg_word,
	input  wire tfce_pkg::dp_cmd_t  cmd,
	output tfce_pkg::dp_sts_t       sts,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tfce_pkg::out_word_t     out_word
);

	tfce_pkg::flow_t                  mem_q [tfce_pkg::CAPACITY];
	tfce_pkg::flow_t                  rd_q;
	tfce_pkg::flow_t                  upd;
	tfce_pkg::flow_t                  new_rec;
	tfce_pkg::flow_t                  emit_rec;
	tfce_pkg::flow_t                  hold_q;
	logic                             hold_v_q;
	logic                             push;
	tfce_pkg::in_word_t               in_q;
	logic [31:0]                      act_q;
	logic [31:0]                      inact_q;
	logic [31:0]                      age_first;
	logic [31:0]                      age_last;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_word;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[cmd.rd_slot];
		end
		if (cmd.wr_upd) begin
			mem_q[cmd.wr_slot] <= upd;
		end else if (cmd.wr_new) begin
			mem_q[cmd.wr_slot] <= new_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= tfce_pkg::TIMEOUT_RESET;
			inact_q <= tfce_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (tfce_pkg::reg_idx_t'(cfg_word.index))
				tfce_pkg::REG_ACTIVE:   act_q   <= cfg_word.data;
				tfce_pkg::REG_INACTIVE: inact_q <= cfg_word.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		age_first = in_q.timestamp_ms - rd_q.first_ms;
		age_last  = in_q.timestamp_ms - rd_q.last_ms;

		new_rec.src_addr = in_q.src_addr;
		new_rec.dst_addr = in_q.dst_addr;
		new_rec.src_port = in_q.src_port;
		new_rec.dst_port = in_q.dst_port;
		new_rec.protocol = in_q.protocol;
		new_rec.tos      = in_q.tos;
		new_rec.packets  = 32'd1;
		new_rec.octets   = {16'd0, in_q.ip_length};
		new_rec.first_ms = in_q.timestamp_ms;
		new_rec.last_ms  = in_q.timestamp_ms;
		new_rec.flags    = in_q.hdr_flags;

		upd         = rd_q;
		upd.packets = rd_q.packets + 32'd1;
		upd.octets  = rd_q.octets + {16'd0, in_q.ip_length};
		upd.last_ms = in_q.timestamp_ms;
		upd.flags   = rd_q.flags | in_q.hdr_flags;

		sts.cmd_flush = in_q.cmd;
		sts.live      = (age_first < act_q) && (age_last < inact_q);
		sts.hit       = (rd_q.src_addr == in_q.src_addr) && (rd_q.dst_addr == in_q.dst_addr)
			&& (rd_q.src_port == in_q.src_port) && (rd_q.dst_port == in_q.dst_port)
			&& (rd_q.protocol == in_q.protocol) && (rd_q.tos == in_q.tos);
		sts.close_now = |(in_q.hdr_flags & (tfce_pkg::FLAG_FIN | tfce_pkg::FLAG_RST));
		sts.out_busy  = out_valid && !out_ready;

		emit_rec = cmd.emit_new ? new_rec : (cmd.wr_upd ? upd : rd_q);
		push     = (cmd.emit || cmd.emit_last) && hold_v_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_q <= emit_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (cmd.emit) begin
			hold_v_q <= 1'b1;
		end else if (cmd.emit_last) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_word.out_src_addr <= hold_q.src_addr;
			out_word.out_dst_addr <= hold_q.dst_addr;
			out_word.out_src_port <= hold_q.src_port;
			out_word.out_dst_port <= hold_q.dst_port;
			out_word.out_protocol <= hold_q.protocol;
			out_word.out_tos      <= hold_q.tos;
			out_word.packet_count <= hold_q.packets;
			out_word.octet_count  <= hold_q.octets;
			out_word.first_ms     <= hold_q.first_ms;
			out_word.last_ms      <= hold_q.last_ms;
			out_word.flags_seen   <= hold_q.flags;
			out_word.last_of_run  <= cmd.emit_last;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_last) |-> !(out_valid && !out_ready))
		else $error("emit while output word stalled");
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_upd && cmd.wr_new))
		else $error("two writes to flow store");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output word dropped");
	a_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit && cmd.emit_last))
		else $error("hold and release in one cycle");

endmodule
`default_nettype wire

/* hdl/tfce_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfce_ctrl: flow table walk controller
// Keeps the insertion order list and entry count, walks the table for each
// packet, and sequences expiry, update, eviction, insertion and flush.
// ----------------------------------------------------------------------------
module tfce_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output tfce_pkg::dp_cmd_t      cmd,
	input  wire tfce_pkg::dp_sts_t sts
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b0_0000_0001,
		S_READ   = 9'b0_0000_0010,
		S_CHECK  = 9'b0_0000_0100,
		S_EVICT  = 9'b0_0000_1000,
		S_EVRD   = 9'b0_0001_0000,
		S_EVOUT  = 9'b0_0010_0000,
		S_INSERT = 9'b0_0100_0000,
		S_NEWOUT = 9'b0_1000_0000,
		S_DONE   = 9'b1_0000_0000
	} state_t;

	localparam logic [tfce_pkg::CNT_W-1:0] CAP = tfce_pkg::CNT_W'(tfce_pkg::CAPACITY);

	state_t                          state_q;
	logic [tfce_pkg::SLOT_W-1:0]     order_q [tfce_pkg::CAPACITY];
	logic [tfce_pkg::CNT_W-1:0]      count_q;
	logic [tfce_pkg::CNT_W-1:0]      pos_q;
	logic                            matched_q;
	logic [tfce_pkg::SLOT_W-1:0]     pos_idx;
	logic [tfce_pkg::SLOT_W-1:0]     cur_slot;
	logic                            remove;
	logic [tfce_pkg::CNT_W-1:0]      rm_pos;
	logic [tfce_pkg::CNT_W-1:0]      cnt_after;
	logic [tfce_pkg::CNT_W-1:0]      pos_next;
	logic                            flush;
	logic                            expire;
	logic                            match;

	assign pos_idx   = pos_q[tfce_pkg::SLOT_W-1:0];
	assign cur_slot  = order_q[pos_idx];
	assign in_ready  = (state_q == S_IDLE);
	assign flush     = sts.cmd_flush;
	assign expire    = !sts.live;
	assign match     = sts.live && sts.hit;
	assign cnt_after = count_q - 1'b1;

	always_comb begin
		cmd          = '0;
		cmd.rd_slot  = cur_slot;
		cmd.wr_slot  = cur_slot;
		remove       = 1'b0;
		rm_pos       = pos_q;
		pos_next     = pos_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_CHECK: begin
				if (!sts.out_busy) begin
					if (flush) begin
						pos_next = pos_q + 1'b1;
						cmd.emit = 1'b1;
					end else if (expire || (match && sts.close_now)) begin
						cmd.wr_upd = match;
						remove     = 1'b1;
						cmd.emit   = 1'b1;
					end else begin
						cmd.wr_upd = match;
						pos_next   = pos_q + 1'b1;
					end
				end
			end
			S_EVRD: begin
				cmd.rd_slot = order_q[0];
				cmd.rd_en   = 1'b1;
			end
			S_EVOUT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					remove   = 1'b1;
					rm_pos   = '0;
				end
			end
			S_INSERT: begin
				cmd.wr_slot = order_q[count_q[tfce_pkg::SLOT_W-1:0]];
				cmd.wr_new  = 1'b1;
			end
			S_NEWOUT: begin
				if (!sts.out_busy) begin
					cmd.emit      = 1'b1;
					cmd.emit_new  = 1'b1;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit_last = 1'b1;
				end
			end
			S_EVICT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			matched_q <= 1'b0;
			for (int i = 0; i < tfce_pkg::CAPACITY; i++) begin
				order_q[i] <= tfce_pkg::SLOT_W'(i);
			end
		end else begin
			if (remove) begin
				for (int i = 0; i < tfce_pkg::CAPACITY; i++) begin
					if (tfce_pkg::CNT_W'(i) >= rm_pos && tfce_pkg::CNT_W'(i) + 1'b1 < count_q) begin
						order_q[i] <= order_q[i+1 < tfce_pkg::CAPACITY ? i+1 : i];
					end
				end
				order_q[cnt_after[tfce_pkg::SLOT_W-1:0]] <=
					order_q[rm_pos[tfce_pkg::SLOT_W-1:0]];
				count_q <= cnt_after;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pos_q     <= '0;
						matched_q <= 1'b0;
						state_q   <= S_EVICT;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!sts.out_busy) begin
						pos_q <= pos_next;
						if (match) begin
							matched_q <= 1'b1;
						end
						if (flush) begin
							if (pos_next == count_q) begin
								count_q <= '0;
								state_q <= S_DONE;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							state_q <= S_EVICT;
						end
					end
				end
				S_EVICT: begin
					if (pos_q < count_q) begin
						state_q <= S_READ;
					end else if (flush || matched_q) begin
						state_q <= S_DONE;
					end else if (count_q >= CAP) begin
						state_q <= S_EVRD;
					end else begin
						state_q <= S_INSERT;
					end
				end
				S_EVRD: begin
					state_q <= S_EVOUT;
				end
				S_EVOUT: begin
					if (!sts.out_busy) begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					count_q <= count_q + 1'b1;
					state_q <= sts.close_now ? S_NEWOUT : S_DONE;
				end
				S_NEWOUT: begin
					if (!sts.out_busy) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("entry count beyond capacity");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word accepted during walk");
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |-> (count_q < CAP))
		else $error("insert into full table");

endmodule
`default_nettype wire

/* hdl/tcp_flow_cache_exporter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_flow_cache_exporter: TCP flow cache with flow export
// A packet word walks the flow table oldest first, visiting each stored
// entry with a list step, a store read and a check; a live matching entry is
// updated, and an expired or closing one is removed and exported. An unmatched
// packet inserts a new flow, first evicting and exporting the oldest flow
// when the table is full, and a closing new flow is exported at once. A flush
// exports every stored entry. Each exported record waits in a hold register
// until the next one, so the final record of a run can be marked, and the walk
// stalls while the output register holds a word not yet accepted. The walk
// rate is set by the single-port flow record store read once per entry.
// ----------------------------------------------------------------------------
module tcp_flow_cache_exporter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tfce_in_if.sink    in_ch,
	tfce_out_if.source out_ch,
	tfce_cfg_if.sink   cfg
);

	tfce_pkg::dp_cmd_t dp_cmd;
	tfce_pkg::dp_sts_t dp_sts;

	assign cfg.ready = 1'b1;

	tfce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (dp_cmd),
		.sts      (dp_sts)
	);

	tfce_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_ch.data),
		.cfg_we    (cfg.valid),
		.cfg_word  (cfg.data),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_word  (out_ch.data)
	);

endmodule
`default_nettype wire
